@@ design/sorted_set_table_defines.svh @@
// Assertion macros shared by the sorted set table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_set_table: check failed");

// next-cycle implication
`define SST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_set_table: check failed");

`endif

@@ design/sst_pkg.sv @@
// Types, constants and codes for the sorted set table.
// No dependencies; imported by sst_cell and sorted_set_table.
package sst_pkg;

  localparam int unsigned CAP   = 16;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ design/sst_cell.sv @@
// One slot of the sorted chain: holds a key, compares it, shifts with neighbors.
// Depends on sst_pkg.
module sst_cell import sst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     valid_i,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic                     left_lt_i,
  input  logic signed [KEY_W-1:0]  left_data_i,
  input  logic signed [KEY_W-1:0]  right_data_i,
  output logic signed [KEY_W-1:0]  data_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic signed [KEY_W-1:0] entry_q, entry_d;
  logic                    lt_q, lt_d;
  logic                    eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid_i && (entry_q < key_i);
      eq_d = valid_i && (entry_q == key_i);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_q) begin
      entry_d = left_lt_i ? key_i : left_data_i;
    end else if (ctrl_i.rem && !lt_q) begin
      entry_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

@@ design/sorted_set_table.sv @@
// Sorted set table top: request control, count register and chain of sst_cell.
// Depends on sst_pkg, sst_cell and sorted_set_table_defines.svh.
//
//   channel   direction  handshake              payload
//   request   in         start_i / busy_o       operation_i, key_i
//   result    out        done_o (1-cycle pulse) ok_o, full_res_o, position_o,
//                                               entry_count_o
//
// A request passes a compare in every cell (ST_CMP), then the update/shift
// (ST_UPD), then the result pulse, during which the next request can already
// be taken, as busy_o is already low while the result pulse is high.
// Reset clears count and control; cell keys are undefined until written.
// The receiver cannot stall; done_o is high for exactly one cycle per request.
`include "sorted_set_table_defines.svh"

module sorted_set_table import sst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [KEY_W-1:0] key_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic                    full_res_o,
  output logic [POS_W-1:0]        position_o,
  output logic [POS_W-1:0]        entry_count_o
);

  state_e                  state_q, state_d;
  logic [OP_W-1:0]         op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    done_q, done_d;
  logic                    ok_q, ok_d;
  logic                    full_q, full_d;
  logic [POS_W-1:0]        pos_q, pos_d;

  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] cell_data [CAP];
  logic [CAP-1:0]          lt_vec;
  logic [CAP-1:0]          eq_vec;
  logic [CNT_W-1:0]        idx;
  logic                    found;
  logic [POS_W-1:0]        pos_hit;
  logic                    accept;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign idx     = CNT_W'($countones(lt_vec));
  assign found   = |eq_vec;
  assign pos_hit = POS_W'({1'b0, idx} + (CNT_W + 1)'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_d      = 1'b0;
    ok_d        = ok_q;
    full_d      = full_q;
    pos_d       = pos_q;
    ctrl.cmp_en = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        ok_d    = 1'b0;
        full_d  = 1'b0;
        pos_d   = '0;
        case (op_q)
          OP_INSERT: begin
            if (found) begin
              pos_d = pos_hit;
            end else if (count_q == CNT_W'(CAP)) begin
              full_d = 1'b1;
            end else begin
              ctrl.ins = 1'b1;
              count_d  = count_q + CNT_W'(1);
              ok_d     = 1'b1;
              pos_d    = pos_hit;
            end
          end
          OP_REMOVE: begin
            if (found) begin
              ctrl.rem = 1'b1;
              count_d  = count_q - CNT_W'(1);
              ok_d     = 1'b1;
            end
          end
          OP_QUERY: begin
            if (found) begin
              ok_d  = 1'b1;
              pos_d = pos_hit;
            end
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      full_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
      full_q  <= full_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
  end

  for (genvar j = 0; j < CAP; j++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_data;
    logic signed [KEY_W-1:0] right_data;

    if (j == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_data = key_q;
    end else begin : g_mid
      assign left_lt   = lt_vec[j-1];
      assign left_data = cell_data[j-1];
    end

    if (j == CAP - 1) begin : g_last
      assign right_data = cell_data[j];
    end else begin : g_inner
      assign right_data = cell_data[j+1];
    end

    sst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (CNT_W'(j) < count_q),
      .key_i        (key_q),
      .left_lt_i    (left_lt),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .data_o       (cell_data[j]),
      .lt_o         (lt_vec[j]),
      .eq_o         (eq_vec[j])
    );
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign full_res_o    = full_q;
  assign position_o    = pos_q;
  assign entry_count_o = POS_W'(count_q);

  `SST_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(CAP))
  `SST_ASSERT_IMP(a_full_not_ok, done_o && full_res_o, !ok_o && (position_o == '0))
  `SST_ASSERT_NXT(a_done_after_upd, state_q == ST_UPD, done_o && (state_q == ST_IDLE))
  `SST_ASSERT_IMP(a_count_moves_in_upd, !$stable(count_q), done_o)
  `SST_ASSERT_NXT(a_accept_to_cmp, accept, state_q == ST_CMP)

endmodule

@@ verif/sorted_set_table_test.sv @@
// Self-checking testbench for sorted_set_table: directed and random insert, remove and
// query requests against an ordered-set scoreboard, with random sender gaps.
// Depends on sst_pkg and the sorted_set_table RTL.
`timescale 1ns / 100ps

module sorted_set_table_test;
  import sst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_N        = 20;
  localparam int PHASES        = 14;
  localparam int PHASE_LEN     = 125;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic             ok;
    logic             full;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cnt;
  } set_result_t;

  class ordered_set_model;
    logic signed [KEY_W-1:0] keys [CAP];
    int                      held;
    set_result_t             pending_results [$];
    int                      mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
      set_result_t r;
      int          idx;
      bit          hit;
      r   = '0;
      idx = 0;
      while (idx < held && keys[idx] < key) idx++;
      hit = (idx < held) && (keys[idx] == key);
      case (op)
        OP_INSERT: begin
          if (hit) begin
            r.pos = POS_W'(idx + 1);
          end else if (held >= CAP) begin
            r.full = 1'b1;
          end else begin
            for (int j = held; j > idx; j--) keys[j] = keys[j-1];
            keys[idx] = key;
            held++;
            r.ok  = 1'b1;
            r.pos = POS_W'(idx + 1);
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (int j = idx; j + 1 < held; j++) keys[j] = keys[j+1];
            held--;
            r.ok = 1'b1;
          end
        end
        OP_QUERY: begin
          if (hit) begin
            r.ok  = 1'b1;
            r.pos = POS_W'(idx + 1);
          end
        end
        default: ;
      endcase
      r.cnt = POS_W'(held);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic ok, logic full, logic [POS_W-1:0] pos,
                               logic [POS_W-1:0] cnt);
      set_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0d, actual %0d", e.ok, ok);
        mismatches++;
      end
      if (full !== e.full) begin
        $error("full_res: expected %0d, actual %0d", e.full, full);
        mismatches++;
      end
      if (pos !== e.pos) begin
        $error("position: expected %0d, actual %0d", e.pos, pos);
        mismatches++;
      end
      if (cnt !== e.cnt) begin
        $error("entry_count: expected %0d, actual %0d", e.cnt, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [OP_W-1:0]         operation_i = '0;
  logic signed [KEY_W-1:0] key_i = '0;
  logic                    done_o;
  logic                    ok_o;
  logic                    full_res_o;
  logic [POS_W-1:0]        position_o;
  logic [POS_W-1:0]        entry_count_o;

  ordered_set_model        sb = new();
  logic signed [KEY_W-1:0] key_pool [POOL_N];

  sorted_set_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .full_res_o    (full_res_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(ok_o, full_res_o, position_o, entry_count_o);
      if (start_i && !busy_o) sb.note_request(operation_i, key_i);
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    @(negedge clk_i);
    start_i     = 1'b1;
    operation_i = op;
    key_i       = key;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_results.size() > 0) @(negedge clk_i);
  endtask

  task automatic fill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      case ($urandom_range(0, 3))
        0: key_pool[i] = int'($urandom_range(0, 40)) - 20;
        1: begin
          case ($urandom_range(0, 5))
            0: key_pool[i] = 32'sh8000_0000;
            1: key_pool[i] = 32'sh8000_0001;
            2: key_pool[i] = 32'sh7fff_ffff;
            3: key_pool[i] = 32'sh7fff_fffe;
            4: key_pool[i] = 32'sh0000_0000;
            default: key_pool[i] = -32'sd1;
          endcase
        end
        default: key_pool[i] = $urandom();
      endcase
    end
  endtask

  initial begin
    int                      ins_w;
    int                      r;
    bit                      gaps_on;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, duplicates, first/last entry, unused code
    send_request(OP_QUERY, 32'sd0);
    send_request(OP_REMOVE, 32'sd5);
    send_request(OP_UNUSED, 32'sd0);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_QUERY, 32'sh8000_0000);
    send_request(OP_QUERY, 32'sh7fff_ffff);
    send_request(OP_QUERY, 32'sd1);
    send_request(OP_REMOVE, 32'sh8000_0000);
    send_request(OP_REMOVE, 32'sh8000_0000);
    send_request(OP_REMOVE, 32'sh7fff_ffff);
    send_request(OP_UNUSED, -32'sd1);
    send_request(OP_INSERT, 32'sh5555_5555);
    send_request(OP_INSERT, 32'shaaaa_aaaa);
    send_request(OP_QUERY, 32'shaaaa_aaaa);
    send_request(OP_INSERT, 32'shaaaa_aaaa);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      fill_pool();
      gaps_on = (p < PHASES - 2) && (p % 3 != 2);
      ins_w   = (p % 2 == 0) ? 70 : 25;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_UNUSED;
        else if (r < 3 + ins_w) op = OP_INSERT;
        else if (r < 3 + ins_w + (97 - ins_w) / 2) op = OP_REMOVE;
        else op = OP_QUERY;
        if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, POOL_N - 1)];
        else key = $urandom();
        if (gaps_on && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 17));
        send_request(op, key);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sorted_set_table.f @@
+incdir+design
design/sst_pkg.sv
design/sst_cell.sv
design/sorted_set_table.sv
verif/sorted_set_table_test.sv
